[src/csm_pkg.sv]
// Shared constants, types and helpers for the circular angle smoother.
package csm_pkg;

  localparam int TAPS        = 8;
  localparam int NUM_WEIGHTS = 8;
  localparam int SLOT_W      = 3;
  localparam int K_W         = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int WIDX_W      = 3;
  localparam int IDX_W       = 8;
  localparam int RAW_W       = 17;
  localparam int ANGLE_W     = 16;
  localparam int WEIGHT_W    = 17;
  localparam int STAB_W      = 17;
  localparam int FOLD_W      = 15;
  localparam int TERM_W      = 32;
  localparam int MAG_W       = 34;
  localparam int SUM_W       = 36;
  localparam int Q_W         = 21;
  localparam int N_W         = 25;
  localparam int RECIP_W     = 26;
  localparam int PROD_W      = N_W + RECIP_W;
  localparam int DEV_W       = 20;
  localparam int RECIP_SHIFT = 31;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [ANGLE_W-1:0] FULL_TURN     = 16'd46080;
  localparam logic [ANGLE_W-1:0] HALF_TURN     = 16'd23040;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 16'd11520;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER = 16'd34560;
  localparam logic [STAB_W-1:0]  ONE_Q16       = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd8192;
  localparam logic [MAG_W-1:0]   STAB_BIAS     = 34'd11520;
  localparam logic [SUM_W-1:0]   ROUND_BIAS    = 36'd32768;
  // ceil(2^31 / 45); exact floor division by 45 for any 25-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_45      = 26'd47721859;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NUM_WEIGHTS-1:0] weight_bank_t;

  typedef struct packed {
    logic                push;
    logic [ANGLE_W-1:0]  angle;
  } csm_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csm_qstat_t;

  typedef struct packed {
    logic                valid;
    logic [ANGLE_W-1:0]  angle;
  } csm_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_SCALE,
    ST_RECIP,
    ST_OUT
  } back_state_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (int'(s) + 1 >= TAPS) r = '0;
    else r = s + 1'b1;
    return r;
  endfunction

endpackage

[src/csm_regs.sv]
// Weight register bank written through the configuration channel.
module csm_regs
  import csm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [WEIGHT_W-1:0] cfg_data,
  output weight_bank_t        weights
);

  weight_t sat_data;

  assign cfg_ready = 1'b1;
  assign sat_data  = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_WEIGHTS))) begin
      weights[cfg_index[WIDX_W-1:0]] <= sat_data;
    end
  end

endmodule

[src/csm_front.sv]
// Input side: takes requests, folds the angle into 0..360 degrees and queues it.
module csm_front
  import csm_pkg::*;
(
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] raw_angle,
  input  csm_qstat_t              qstat,
  output csm_push_t               push
);

  localparam logic signed [RAW_W-1:0] FULL_S = {1'b0, FULL_TURN};

  logic signed [RAW_W-1:0] shifted;

  // One turn is added to a negative angle; anything still outside is saturated.
  assign shifted = raw_angle[RAW_W-1] ? raw_angle + FULL_S : raw_angle;

  always_comb begin
    push.push = in_valid && !qstat.full;
    if (shifted[RAW_W-1]) push.angle = '0;
    else if (shifted > FULL_S) push.angle = FULL_TURN;
    else push.angle = shifted[ANGLE_W-1:0];
  end

  assign in_stall = qstat.full;

endmodule

[src/csm_queue.sv]
// Two-entry queue between the input side and the averaging engine.
module csm_queue
  import csm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  csm_push_t  push,
  input  logic       pop,
  output csm_qstat_t qstat,
  output csm_head_t  head
);

  logic [ANGLE_W-1:0] entry [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign head.valid  = !qstat.empty;
  assign head.angle  = entry[rd_ptr];
  assign do_push     = push.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entry[wr_ptr] <= push.angle;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

[src/csm_back.sv]
// Averaging engine: ring of recent angles, one weighted tap per cycle, final scaling.
module csm_back
  import csm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  csm_head_t           head,
  output logic                pop,
  input  weight_bank_t        weights,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ANGLE_W-1:0]  smoothed_angle,
  output logic [STAB_W-1:0]   stability
);

  localparam logic signed [Q_W-1:0] FULL_Q = {{(Q_W-ANGLE_W){1'b0}}, FULL_TURN};
  localparam logic [K_W-1:0]        K_LAST = K_W'(TAPS - 1);

  back_state_t state, state_next;

  logic [ANGLE_W-1:0]      ring [TAPS];
  logic [SLOT_W-1:0]       newest;
  logic [SLOT_W-1:0]       slot;
  logic [K_W-1:0]          k;
  logic [ANGLE_W-1:0]      base;
  logic [TERM_W-1:0]       term;
  logic                    term_neg;
  logic                    term_valid;
  logic signed [SUM_W-1:0] signed_sum;
  logic [MAG_W-1:0]        mag_sum;
  logic [ANGLE_W-1:0]      angle_res;
  logic [N_W-1:0]          n_val;
  logic [DEV_W-1:0]        dev;
  logic                    load_out;

  logic [SLOT_W-1:0]       new_slot;
  logic [ANGLE_W-1:0]      other;
  logic [ANGLE_W-1:0]      diff;
  logic [FOLD_W-1:0]       fold;
  logic                    left;
  logic [TERM_W-1:0]       prod;
  logic signed [SUM_W-1:0] biased;
  logic signed [Q_W-1:0]   q_raw;
  logic signed [Q_W-1:0]   q_wrap;
  logic [MAG_W-1:0]        mag_biased;
  logic [PROD_W-1:0]       recip_prod;

  assign new_slot = next_slot(newest);

  // Tap datapath: folded distance to the newest angle and its direction.
  always_comb begin
    other = ring[slot];
    diff  = (base >= other) ? base - other : other - base;
    fold  = (diff < HALF_TURN) ? diff[FOLD_W-1:0] : FOLD_W'(FULL_TURN - diff);
    // The seam cases decide direction before the plain comparison does.
    if (base < QUARTER_TURN && other > THREE_QUARTER && other <= FULL_TURN) left = 1'b1;
    else if (other < QUARTER_TURN && base > THREE_QUARTER && base <= FULL_TURN) left = 1'b0;
    else left = (base > other);
    prod = TERM_W'(weights[k]) * TERM_W'(fold);
  end

  // Rounding divide by 65536, then one wrap and a clamp.
  always_comb begin
    biased = signed_sum + $signed(ROUND_BIAS);
    q_raw  = $signed({{(Q_W-ANGLE_W){1'b0}}, base})
           + Q_W'($signed(biased[SUM_W-1:16]));
    if (q_raw[Q_W-1]) q_wrap = q_raw + FULL_Q;
    else if (q_raw > FULL_Q) q_wrap = q_raw - FULL_Q;
    else q_wrap = q_raw;
    mag_biased = mag_sum + STAB_BIAS;
    recip_prod = PROD_W'(n_val) * PROD_W'(RECIP_45);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (head.valid) state_next = ST_MAC;
      ST_MAC:   if (k == K_LAST) state_next = ST_ACC;
      ST_ACC:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_RECIP;
      ST_RECIP: state_next = ST_OUT;
      ST_OUT:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: pop      = head.valid;
      ST_OUT:  load_out = !out_valid || !out_stall;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      newest     <= SLOT_W'(TAPS - 1);
      out_valid  <= 1'b0;
      term_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) ring[i] <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid      <= 1'b1;
        smoothed_angle <= angle_res;
        stability      <= (dev > DEV_W'(ONE_Q16)) ? '0 : ONE_Q16 - STAB_W'(dev);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        newest         <= new_slot;
        ring[new_slot] <= head.angle;
        slot           <= new_slot;
        base           <= head.angle;
        k              <= '0;
        signed_sum     <= '0;
        mag_sum        <= '0;
        term_valid     <= 1'b0;
      end
      if (state == ST_MAC) begin
        term       <= prod;
        term_neg   <= left;
        term_valid <= 1'b1;
        k          <= k + 1'b1;
        slot       <= next_slot(slot);
      end
      // Each product is registered into term and added in the cycle after.
      if ((state == ST_MAC || state == ST_ACC) && term_valid) begin
        mag_sum <= mag_sum + MAG_W'(term);
        if (term_neg) signed_sum <= signed_sum - $signed(SUM_W'(term));
        else signed_sum <= signed_sum + $signed(SUM_W'(term));
      end
      if (state == ST_ACC) term_valid <= 1'b0;
      if (state == ST_SCALE) begin
        if (q_wrap[Q_W-1]) angle_res <= '0;
        else if (q_wrap > FULL_Q) angle_res <= FULL_TURN;
        else angle_res <= q_wrap[ANGLE_W-1:0];
        // Dividing by 23040 is a shift by 9 followed by a divide by 45.
        n_val <= mag_biased[MAG_W-1:9];
      end
      if (state == ST_RECIP) dev <= recip_prod[RECIP_SHIFT +: DEV_W];
    end
  end

endmodule

[src/circular_angle_smoother_top.sv]
// Top level of the circular angle smoother.
//
// Input requests carry raw_angle (signed, 1/128 degree) on in_valid/in_stall; each
// is accepted at a clock edge with in_valid high and in_stall low. Every request
// yields exactly one result, smoothed_angle and stability, on out_valid/out_stall.
// Weights 0..7 are written on the cfg channel (cfg_ready is always high); values
// above 1.0 saturate, indexes above 7 are ignored. The user must write them only
// while the block is idle; the block itself does not enforce it.
// A two-entry queue sits behind the input, so requests are taken while the
// engine works. For each request the engine writes the ring, steps through the
// multiply-accumulate loop once per tap (TAPS = 8), then drains the last
// product, scales the sums, applies the reciprocal and loads the output
// register. It takes the next request from the queue only after the result of
// the last one has been loaded into the output register.
// When the receiver stalls the result holds in the output register, the engine
// waits in its final step, and the queue fills before in_stall rises.
// Reset clears the ring to zero, sets weights to 8192 and empties the queue.
module circular_angle_smoother_top
  import csm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] raw_angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ANGLE_W-1:0]      smoothed_angle,
  output logic [STAB_W-1:0]       stability,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [WEIGHT_W-1:0]     cfg_data
);

  weight_bank_t weights;
  csm_push_t    push;
  csm_qstat_t   qstat;
  csm_head_t    head;
  logic         pop;

  csm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weights   (weights)
  );

  csm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .raw_angle (raw_angle),
    .qstat     (qstat),
    .push      (push)
  );

  csm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  csm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .weights        (weights),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .smoothed_angle (smoothed_angle),
    .stability      (stability)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !qstat.full)
    else $error("push into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smoothed_angle <= FULL_TURN) && (stability <= ONE_Q16))
    else $error("result out of range");

endmodule

[verif/tb_circular_angle_smoother_top.sv]
// Self-checking testbench for the circular angle smoother: directed table, random headings.
`timescale 1ns / 100ps

module tb_circular_angle_smoother_top;
  import csm_pkg::*;

  localparam longint TURN_FULL    = 46080;
  localparam longint TURN_HALF    = 23040;
  localparam longint TURN_QUARTER = 11520;
  localparam longint TURN_3Q      = 34560;
  localparam longint GAIN_UNITY   = 65536;
  localparam int     QUIET_LIMIT  = 4000;
  localparam int     END_CYCLES   = 40;

  localparam logic [IDX_W-1:0] REG_WEIGHT_0     = 8'd0;
  localparam logic [IDX_W-1:0] REG_WEIGHT_LAST  = 8'd7;
  localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = 8'd8;
  localparam logic [IDX_W-1:0] REG_UNUSED_LAST  = 8'd255;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [STAB_W-1:0]  stab;
  } heading_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic                    typed;
    logic [ANGLE_W-1:0]      angle;
    logic [STAB_W-1:0]       stab;
  } heading_row_t;

  // Rows with typed results run right after reset, while the ring holds only
  // 0 and 360 degree entries, so every distance folds to zero.
  localparam heading_row_t DIRECTED [24] = '{
    '{17'sd0,       1'b1, 16'd0,     17'd65536},
    '{17'sd46080,   1'b1, 16'd46080, 17'd65536},
    '{-17'sd46080,  1'b1, 16'd0,     17'd65536},
    '{17'h10000,    1'b1, 16'd0,     17'd65536},
    '{17'h0FFFF,    1'b1, 16'd46080, 17'd65536},
    '{17'sd46081,   1'b1, 16'd46080, 17'd65536},
    '{-17'sd46081,  1'b1, 16'd0,     17'd65536},
    '{-17'sd1,      1'b0, 16'd0,     17'd0},
    '{17'sd23040,   1'b0, 16'd0,     17'd0},
    '{17'sd11520,   1'b0, 16'd0,     17'd0},
    '{17'sd11519,   1'b0, 16'd0,     17'd0},
    '{17'sd34560,   1'b0, 16'd0,     17'd0},
    '{17'sd34561,   1'b0, 16'd0,     17'd0},
    '{17'sd100,     1'b0, 16'd0,     17'd0},
    '{17'sd45980,   1'b0, 16'd0,     17'd0},
    '{17'sd200,     1'b0, 16'd0,     17'd0},
    '{17'sd45900,   1'b0, 16'd0,     17'd0},
    '{17'sd23039,   1'b0, 16'd0,     17'd0},
    '{17'sd23041,   1'b0, 16'd0,     17'd0},
    '{-17'sd23040,  1'b0, 16'd0,     17'd0},
    '{17'sd12345,   1'b0, 16'd0,     17'd0},
    '{17'sd30000,   1'b0, 16'd0,     17'd0},
    '{-17'sd100,    1'b0, 16'd0,     17'd0},
    '{17'sd5,       1'b0, 16'd0,     17'd0}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [RAW_W-1:0] raw_angle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ANGLE_W-1:0]      smoothed_angle;
  logic [STAB_W-1:0]       stability;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [WEIGHT_W-1:0]     cfg_data = '0;

  // Local copy of the block's state.
  logic [WEIGHT_W-1:0] gain [NUM_WEIGHTS];
  logic [ANGLE_W-1:0]  heading_ring [8];
  int                  head_slot;

  heading_t pending_headings [$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  int       drift_center = 9000;

  int stall_mode = 0;
  int stall_left = 0;
  int run_left = 0;
  bit run_stall = 1'b0;

  circular_angle_smoother_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_angle      (raw_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .smoothed_angle (smoothed_angle),
    .stability      (stability),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit heading_left_of(input longint base, input longint other);
    if (base >= 0 && base < TURN_QUARTER && other <= TURN_FULL && other > TURN_3Q)
      return 1'b1;
    if (other >= 0 && other < TURN_QUARTER && base <= TURN_FULL && base > TURN_3Q)
      return 1'b0;
    return base > other;
  endfunction

  // Pushes one heading into the ring and returns the weighted circular average and its stability.
  function automatic heading_t smooth_heading(input logic signed [RAW_W-1:0] raw);
    longint   a, other, d, f, term, ssum, q;
    longint   msum, dev;
    int       slot, k;
    heading_t r;
    a = raw;
    if (a < 0) a += TURN_FULL;
    if (a < 0) a = 0;
    if (a > TURN_FULL) a = TURN_FULL;
    head_slot = (head_slot + 1 >= TAPS) ? 0 : head_slot + 1;
    heading_ring[head_slot] = a[ANGLE_W-1:0];
    ssum = 0;
    msum = 0;
    slot = head_slot;
    for (k = 0; k < TAPS; k++) begin
      other = longint'(heading_ring[slot]);
      d = a - other;
      if (d < 0) d = -d;
      f = (d < TURN_HALF) ? d : TURN_FULL - d;
      term = longint'(gain[k]) * f;
      if (heading_left_of(a, other)) ssum -= term;
      else ssum += term;
      msum += term;
      slot = (slot + 1 >= TAPS) ? 0 : slot + 1;
    end
    // Arithmetic shift gives the floor, so ties round upward.
    q = a + ((ssum + 32768) >>> 16);
    if (q < 0) q += TURN_FULL;
    if (q > TURN_FULL) q -= TURN_FULL;
    if (q < 0) q = 0;
    if (q > TURN_FULL) q = TURN_FULL;
    dev = (msum + TURN_QUARTER) / TURN_HALF;
    r.angle = q[ANGLE_W-1:0];
    r.stab  = (dev > GAIN_UNITY) ? '0 : STAB_W'(GAIN_UNITY - dev);
    return r;
  endfunction

  // Mostly a drifting heading with small jitter, plus seam crossings,
  // uniform headings and raw 17-bit noise.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    int sel, v;
    sel = $urandom_range(0, 99);
    drift_center = (drift_center + 46080 + $urandom_range(0, 600) - 300) % 46080;
    if (sel >= 90)
      return RAW_W'($urandom_range(0, 131071));
    if (sel < 55) v = drift_center + int'($urandom_range(0, 3000)) - 1500;
    else if (sel < 70) v = int'($urandom_range(0, 1200)) - 600;
    else v = int'($urandom_range(0, 92160)) - 46080;
    if (v < 0) v += 46080;
    if (v > 46080) v -= 46080;
    if ($urandom_range(0, 3) == 0) v -= 46080;
    return v[RAW_W-1:0];
  endfunction

  task automatic send_angle(input logic signed [RAW_W-1:0] raw, input logic typed,
                            input heading_t typed_res);
    heading_t want;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    raw_angle <= raw;
    do @(posedge clk); while (in_stall);
    want = smooth_heading(raw);
    if (typed) want = typed_res;
    pending_headings.push_back(want);
  endtask

  task automatic send_random(input int count);
    int n;
    for (n = 0; n < count; n++) send_angle(pick_raw(), 1'b0, '0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  task automatic write_weight(input logic [IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_WEIGHT_LAST)
      gain[idx[WIDX_W-1:0]] = (val > GAIN_UNITY) ? WEIGHT_W'(GAIN_UNITY) : val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all_weights(input logic [WEIGHT_W-1:0] val);
    int k;
    for (k = 0; k < NUM_WEIGHTS; k++) write_weight(REG_WEIGHT_0 + IDX_W'(k), val);
  endtask

  task automatic log_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Receiver stall pattern: quiet stretches, light and heavy random stalling,
  // and long alternating runs.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          run_left  = run_stall ? $urandom_range(5, 40) : $urandom_range(1, 20);
        end
        run_left--;
        out_stall <= run_stall;
      end
    endcase
  end

  always @(posedge clk) begin : check_results
    heading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_headings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: angle %0d, stability %0d",
                   $realtime, smoothed_angle, stability);
      end else begin
        want = pending_headings.pop_front();
        if (smoothed_angle !== want.angle)
          log_mismatch("smoothed_angle", want.angle, smoothed_angle);
        if (stability !== want.stab)
          log_mismatch("stability", want.stab, stability);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int       i, k;
    heading_t typed_res;
    for (k = 0; k < NUM_WEIGHTS; k++) gain[k] = WEIGHT_RESET;
    for (k = 0; k < 8; k++) heading_ring[k] = '0;
    head_slot = TAPS - 1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset weights: directed table first, untouched slots still read as zero.
    for (i = 0; i < 24; i++) begin
      typed_res.angle = DIRECTED[i].angle;
      typed_res.stab  = DIRECTED[i].stab;
      send_angle(DIRECTED[i].raw, DIRECTED[i].typed, typed_res);
    end
    send_random(250);
    drain_results();

    // All weights zero: output follows the newest heading.
    set_all_weights('0);
    send_random(100);
    drain_results();

    // Out-of-range weight values saturate to unity; the weight sum of eight
    // drives the wrap and both clamps.
    for (k = 0; k < 4; k++) write_weight(REG_WEIGHT_0 + IDX_W'(k), 17'h1FFFF);
    write_weight(REG_WEIGHT_0 + 8'd4, 17'd65537);
    write_weight(REG_WEIGHT_0 + 8'd5, 17'd65537);
    write_weight(REG_WEIGHT_0 + 8'd6, 17'd65536);
    write_weight(REG_WEIGHT_LAST, 17'd65536);
    send_random(150);
    drain_results();

    // Random full-width data, with writes to unused indexes in between.
    for (k = 0; k < NUM_WEIGHTS; k++) begin
      write_weight(REG_WEIGHT_0 + IDX_W'(k), WEIGHT_W'($urandom_range(0, 131071)));
      write_weight(IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   WEIGHT_W'($urandom_range(0, 131071)));
    end
    write_weight(REG_UNUSED_FIRST, 17'd0);
    write_weight(REG_UNUSED_LAST, 17'h1FFFF);
    send_random(250);
    drain_results();

    // Only weight 7, the tap on the heading just before the newest, is nonzero.
    set_all_weights('0);
    write_weight(REG_WEIGHT_LAST, 17'd65536);
    send_random(150);
    drain_results();

    for (k = 0; k < NUM_WEIGHTS; k++)
      write_weight(REG_WEIGHT_0 + IDX_W'(k), WEIGHT_W'($urandom_range(0, 16384)));
    send_random(200);
    drain_results();

    for (k = 0; k < NUM_WEIGHTS; k++)
      write_weight(REG_WEIGHT_0 + IDX_W'(k), WEIGHT_W'($urandom_range(0, 65536)));
    send_random(200);
    drain_results();

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_headings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
src/csm_pkg.sv
src/csm_regs.sv
src/csm_front.sv
src/csm_queue.sv
src/csm_back.sv
src/circular_angle_smoother_top.sv
verif/tb_circular_angle_smoother_top.sv
